@@ src/http_chunked_body_decoder_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Shared property wrappers, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH

// Implication checked in the same cycle.
`define HCBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define HCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/hcbd_pkg.sv @@
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Shared constants and the result word type.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int unsigned SIZE_WIDTH = 32;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  localparam logic [7:0] SLACK_RESET = 8'd10;
  localparam logic [7:0] SLACK_FLOOR = 8'd2;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] out_byte;
    logic       message_end;
    logic       parse_error;
  } result_t;

endpackage

@@ src/hcbd_parser.sv @@
// ----------------------------------------------------------------------------
// Chunked body parser
// Holds the parse state and the result register, and advances both by one
// byte whenever step_en_i is high.
// ----------------------------------------------------------------------------
module hcbd_parser #(
  parameter int unsigned SizeWidth = hcbd_pkg::SIZE_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  logic [7:0]          byte_i,
  input  logic                start_i,
  input  logic [7:0]          slack_i,
  output hcbd_pkg::result_t   result_o
);

  typedef enum logic [2:0] {
    PhIdle,
    PhSize,
    PhExt,
    PhExtCr,
    PhData,
    PhTrail,
    PhDone,
    PhErr
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [SizeWidth-1:0] chunk_q, chunk_d;
  logic [3:0]           digits_q, digits_d;
  logic [7:0]           line_q, line_d;
  hcbd_pkg::result_t    result_q, result_d;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end
    return v;
  endfunction

  always_comb begin
    phase_e               ph;
    logic [SizeWidth-1:0] chunk;
    logic [3:0]           digits;
    logic [7:0]           line;
    logic [4:0]           hv;
    logic [8:0]           cnt;
    logic [7:0]           limit;

    ph     = start_i ? PhSize : phase_q;
    chunk  = start_i ? '0 : chunk_q;
    digits = start_i ? '0 : digits_q;
    line   = start_i ? '0 : line_q;
    hv     = hex_value(byte_i);
    cnt    = {1'b0, line} + 9'd1;
    limit  = (slack_i < hcbd_pkg::SLACK_FLOOR) ? hcbd_pkg::SLACK_FLOOR : slack_i;

    phase_d  = ph;
    chunk_d  = chunk;
    digits_d = digits;
    line_d   = line;
    result_d = '0;

    case (ph)
      PhSize: begin
        if (!hv[4]) begin
          if (chunk[SizeWidth-1 -: 4] != 4'd0) begin
            phase_d = PhErr;
          end else begin
            chunk_d = {chunk[SizeWidth-5:0], hv[3:0]};
            if (digits != 4'hf) begin
              digits_d = digits + 4'd1;
            end
          end
        end else begin
          line_d  = 8'd1;
          phase_d = (byte_i == hcbd_pkg::CH_CR) ? PhExtCr : PhExt;
        end
      end
      PhExt, PhExtCr: begin
        if (cnt > {1'b0, limit}) begin
          phase_d = PhErr;
        end else begin
          line_d = cnt[7:0];
          if (ph == PhExtCr && byte_i == hcbd_pkg::CH_LF) begin
            if (digits == 4'd0 || chunk == '0) begin
              result_d.message_end = 1'b1;
              phase_d = PhDone;
            end else begin
              phase_d = PhData;
            end
          end else begin
            phase_d = (byte_i == hcbd_pkg::CH_CR) ? PhExtCr : PhExt;
          end
        end
      end
      PhData: begin
        result_d.payload_valid = 1'b1;
        result_d.out_byte      = byte_i;
        chunk_d = chunk - SizeWidth'(1);
        if (chunk == SizeWidth'(1)) begin
          phase_d = PhTrail;
          line_d  = 8'd2;
        end
      end
      PhTrail: begin
        if (line <= 8'd1) begin
          phase_d  = PhSize;
          chunk_d  = '0;
          digits_d = '0;
          line_d   = '0;
        end else begin
          line_d = line - 8'd1;
        end
      end
      default: begin
      end
    endcase

    result_d.parse_error = (phase_d == PhErr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      chunk_q  <= '0;
      digits_q <= '0;
      line_q   <= '0;
      result_q <= '0;
    end else if (step_en_i) begin
      phase_q  <= phase_d;
      chunk_q  <= chunk_d;
      digits_q <= digits_d;
      line_q   <= line_d;
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

@@ src/http_chunked_body_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// HTTP/1.1 chunked body decoder
// Parses a chunked message body one byte per word and emits one result word
// per input word: the payload byte when it is chunk data, plus end and error
// flags.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   in_byte_i, body_start_i
//   out      output     out_valid_o / out_stall_i payload_valid_o, out_byte_o,
//                                                 message_end_o, parse_error_o
//   cfg      input      cfg_we_i                  cfg_wdata_i (size line slack)
//
// One word per cycle is sustained while the output is not stalled; each word
// passes the input register, then the parser state and result register.
// Parser state and result only advance when the input register hands on a word.
// A stall on the output backs up into the input register, which then stalls in.
// Reset clears the parser to idle and loads the slack register with its default.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit #(
  parameter int unsigned SizeWidth = hcbd_pkg::SIZE_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       body_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       payload_valid_o,
  output logic [7:0] out_byte_o,
  output logic       message_end_o,
  output logic       parse_error_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic              in_valid_q, in_valid_d;
  logic [7:0]        in_byte_q;
  logic              in_start_q;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        slack_q;
  logic              advance;
  logic              accept;
  hcbd_pkg::result_t result;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      slack_q     <= hcbd_pkg::SLACK_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        slack_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q  <= in_byte_i;
      in_start_q <= body_start_i;
    end
  end

  hcbd_parser #(
    .SizeWidth(SizeWidth)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_en_i(advance),
    .byte_i   (in_byte_q),
    .start_i  (in_start_q),
    .slack_i  (slack_q),
    .result_o (result)
  );

  assign out_valid_o     = out_valid_q;
  assign payload_valid_o = result.payload_valid;
  assign out_byte_o      = result.out_byte;
  assign message_end_o   = result.message_end;
  assign parse_error_o   = result.parse_error;

endmodule

@@ src/hcbd_checker.sv @@
// ----------------------------------------------------------------------------
// Chunked body decoder port checker
// Watches the top level ports and checks result word consistency over time.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_unit_defines.svh"

module hcbd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       payload_valid_o,
  input logic [7:0] out_byte_o,
  input logic       message_end_o,
  input logic       parse_error_o
);

  `HCBD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o) && $stable(payload_valid_o), "Stalled result word changed.")
  `HCBD_ASSERT_NOW(a_data_excl, out_valid_o && payload_valid_o, !message_end_o && !parse_error_o, "Data word also flags end or error.")
  `HCBD_ASSERT_NOW(a_byte_zero, out_valid_o && !payload_valid_o, out_byte_o == 8'd0, "Non-data word carries a byte.")
  `HCBD_ASSERT_NOW(a_end_excl, out_valid_o && message_end_o, !parse_error_o, "Message end flagged with an error.")

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .payload_valid_o(payload_valid_o),
  .out_byte_o     (out_byte_o),
  .message_end_o  (message_end_o),
  .parse_error_o  (parse_error_o)
);

@@ tb/sv/tb_http_chunked_body_decoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the HTTP/1.1 chunked body decoder
// Streams well-formed chunked bodies, broken size lines and random noise into
// the decoder under random input gaps and output stalls. A behavioral model
// of the parser predicts every result word, and each field is compared.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder_unit;

  localparam int unsigned SIZE_WIDTH  = hcbd_pkg::SIZE_WIDTH;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_WORDS = 80;
  localparam int unsigned HOLD_CYCLES = 150;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SIZE, PH_EXT, PH_EXTCR, PH_DATA, PH_TRAIL, PH_DONE, PH_ERR
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } body_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = '0;
  logic       body_start_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       payload_valid_o;
  logic [7:0] out_byte_o;
  logic       message_end_o;
  logic       parse_error_o;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;

  parse_phase_e          parse_phase = PH_IDLE;
  logic [SIZE_WIDTH-1:0] chunk_left = '0;
  logic [3:0]            digit_count = '0;
  logic [7:0]            line_count = '0;
  logic [7:0]            slack_q = hcbd_pkg::SLACK_RESET;

  body_word_t         pending_words[$];
  hcbd_pkg::result_t  expected_results[$];
  body_word_t         next_word;
  hcbd_pkg::result_t  got_result;
  hcbd_pkg::result_t  want_result;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned phase_words = 0;

  http_chunked_body_decoder_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .body_start_i   (body_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .payload_valid_o(payload_valid_o),
    .out_byte_o     (out_byte_o),
    .message_end_o  (message_end_o),
    .parse_error_o  (parse_error_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void restart_line();
    parse_phase = PH_SIZE;
    chunk_left = '0;
    digit_count = '0;
    line_count = '0;
  endfunction

  function automatic hcbd_pkg::result_t decode_step(input logic [7:0] b, input logic st);
    hcbd_pkg::result_t r;
    int                d;
    logic [7:0]        lim;
    logic [8:0]        cnt;
    r = '0;
    lim = (slack_q < hcbd_pkg::SLACK_FLOOR) ? hcbd_pkg::SLACK_FLOOR : slack_q;
    if (st) restart_line();
    case (parse_phase)
      PH_SIZE: begin
        d = hex_value(b);
        if (d >= 0) begin
          if (chunk_left[SIZE_WIDTH-1 -: 4] != 4'd0) begin
            parse_phase = PH_ERR;
          end else begin
            chunk_left = {chunk_left[SIZE_WIDTH-5:0], d[3:0]};
            if (digit_count != 4'd15) digit_count = digit_count + 4'd1;
          end
        end else begin
          line_count = 8'd1;
          parse_phase = (b == hcbd_pkg::CH_CR) ? PH_EXTCR : PH_EXT;
        end
      end
      PH_EXT, PH_EXTCR: begin
        cnt = {1'b0, line_count} + 9'd1;
        if (cnt > {1'b0, lim}) begin
          parse_phase = PH_ERR;
        end else begin
          line_count = cnt[7:0];
          if (parse_phase == PH_EXTCR && b == hcbd_pkg::CH_LF) begin
            if (digit_count == 4'd0 || chunk_left == '0) begin
              r.message_end = 1'b1;
              parse_phase = PH_DONE;
            end else begin
              parse_phase = PH_DATA;
            end
          end else begin
            parse_phase = (b == hcbd_pkg::CH_CR) ? PH_EXTCR : PH_EXT;
          end
        end
      end
      PH_DATA: begin
        r.payload_valid = 1'b1;
        r.out_byte = b;
        chunk_left = chunk_left - SIZE_WIDTH'(1);
        if (chunk_left == '0) begin
          parse_phase = PH_TRAIL;
          line_count = 8'd2;
        end
      end
      PH_TRAIL: begin
        if (line_count != 8'd0) line_count = line_count - 8'd1;
        if (line_count == 8'd0) restart_line();
      end
      default: ;
    endcase
    r.parse_error = (parse_phase == PH_ERR);
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch in %s at result %0d: got %0h, expected %0h",
             what, results_seen, got, want);
    mismatch_count++;
  endtask

  function automatic bit quiet_stretch();
    return ((cycle_count >> 8) % 4) == 0;
  endfunction

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return $urandom_range(1, 3);
    if (r < 22) return $urandom_range(10, 40);
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i <= '0;
      body_start_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(decode_step(in_byte_i, body_start_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          in_valid_i <= 1'b1;
          in_byte_i <= next_word.data;
          body_start_i <= next_word.start;
          gap_left = quiet_stretch() ? 0 : pick_pause();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_result = {payload_valid_o, out_byte_o, message_end_o, parse_error_o};
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result word", 32'(got_result), 32'd0);
        end else begin
          want_result = expected_results.pop_front();
          if (got_result.payload_valid !== want_result.payload_valid)
            note_mismatch("payload_valid", 32'(got_result.payload_valid),
                          32'(want_result.payload_valid));
          if (got_result.out_byte !== want_result.out_byte)
            note_mismatch("out_byte", 32'(got_result.out_byte),
                          32'(want_result.out_byte));
          if (got_result.message_end !== want_result.message_end)
            note_mismatch("message_end", 32'(got_result.message_end),
                          32'(want_result.message_end));
          if (got_result.parse_error !== want_result.parse_error)
            note_mismatch("parse_error", 32'(got_result.parse_error),
                          32'(want_result.parse_error));
        end
        results_seen++;
      end
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
      end else if (!quiet_stretch()) begin
        stall_left = pick_pause();
      end
      out_stall_i <= (stall_left != 0) || (hold_left != 0);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic put_word(input logic [7:0] b, input logic st);
    body_word_t w;
    w.data = b;
    w.start = st;
    pending_words.push_back(w);
    phase_words++;
  endtask

  // Digits of size after the given number of leading zeros, then an extension
  // of ext_len bytes, then CR LF. No zeros and a zero size give a digitless line.
  task automatic put_size_line(input int unsigned size, input int unsigned zeros,
                               input int unsigned ext_len, input logic st);
    logic [3:0]  nib[$];
    logic [7:0]  c;
    logic [7:0]  letter_base;
    int unsigned v;
    logic        first;
    v = size;
    first = st;
    while (v != 0) begin
      nib.push_front(4'(v & 15));
      v = v >> 4;
    end
    repeat (zeros) nib.push_front(4'd0);
    foreach (nib[i]) begin
      letter_base = ($urandom_range(0, 1) != 0) ? "a" : "A";
      c = (nib[i] < 4'd10) ? ("0" + {4'd0, nib[i]}) : (letter_base + {4'd0, nib[i]} - 8'd10);
      put_word(c, first);
      first = 1'b0;
    end
    if (ext_len != 0) begin
      put_word(";", first);
      first = 1'b0;
      for (int i = 1; i < ext_len; i++) begin
        do c = 8'($urandom_range(0, 255)); while (c == hcbd_pkg::CH_CR);
        put_word(c, 1'b0);
      end
    end
    put_word(hcbd_pkg::CH_CR, first);
    put_word(hcbd_pkg::CH_LF, 1'b0);
  endtask

  task automatic put_message(input int unsigned ext_max);
    int unsigned nchunks;
    int unsigned size;
    nchunks = $urandom_range(1, 3);
    for (int k = 0; k < nchunks; k++) begin
      size = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 24) : $urandom_range(25, 300);
      put_size_line(size, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0,
                    (ext_max != 0 && $urandom_range(0, 2) == 0) ?
                      $urandom_range(1, ext_max) : 0,
                    k == 0);
      repeat (size) put_word(8'($urandom_range(0, 255)), 1'b0);
      if ($urandom_range(0, 3) == 0) begin
        put_word(8'($urandom_range(0, 255)), 1'b0);
        put_word(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        put_word(hcbd_pkg::CH_CR, 1'b0);
        put_word(hcbd_pkg::CH_LF, 1'b0);
      end
    end
    put_size_line(0, ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3),
                  (ext_max != 0 && $urandom_range(0, 2) == 0) ?
                    $urandom_range(1, ext_max) : 0,
                  1'b0);
    repeat ($urandom_range(0, 2)) put_word(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic fill_phase();
    int unsigned lim;
    int unsigned ext_max;
    int unsigned sel;
    int unsigned size;
    int          n;
    lim = (slack_q < hcbd_pkg::SLACK_FLOOR) ? hcbd_pkg::SLACK_FLOOR : slack_q;
    ext_max = (lim - 2 > 12) ? 12 : lim - 2;
    phase_words = 0;
    while (phase_words < PHASE_WORDS) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        put_message(ext_max);
      end else if (sel == 7) begin
        // Nine or more significant digits overflow the size.
        put_word("0" + 8'($urandom_range(1, 9)), 1'b1);
        repeat (8 + $urandom_range(0, 3)) put_word("a" + 8'($urandom_range(0, 5)), 1'b0);
        repeat ($urandom_range(1, 4)) put_word(8'($urandom_range(0, 255)), 1'b0);
      end else if (sel == 8) begin
        // Size line right around the slack limit.
        n = int'(lim) - 3 + int'($urandom_range(0, 3));
        if (n < 1) n = 1;
        size = $urandom_range(1, 15);
        put_size_line(size, 0, n, 1'b1);
        repeat (size) put_word(8'($urandom_range(0, 255)), 1'b0);
        put_word(hcbd_pkg::CH_CR, 1'b0);
        put_word(hcbd_pkg::CH_LF, 1'b0);
        put_size_line(0, 1, 0, 1'b0);
      end else begin
        repeat ($urandom_range(4, 20)) begin
          put_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      end
    end
  endtask

  task automatic drain_all();
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_slack(input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    slack_q = value;
  endtask

  initial begin
    logic [7:0] slack_plan[6];
    slack_plan = '{8'd0, 8'd255, 8'd0, 8'd1, 8'd2, hcbd_pkg::SLACK_RESET};
    slack_plan[2] = 8'($urandom_range(3, 254));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_slack(hcbd_pkg::SLACK_RESET);

    // A word before any body start, then a chunk whose extension is a lone LF.
    put_word(8'hFF, 1'b0);
    put_word("2", 1'b1);
    put_word(hcbd_pkg::CH_LF, 1'b0);
    put_word(hcbd_pkg::CH_CR, 1'b0);
    put_word(hcbd_pkg::CH_LF, 1'b0);
    put_word(8'h00, 1'b0);
    put_word(8'hFF, 1'b0);
    put_word(hcbd_pkg::CH_CR, 1'b0);
    put_word(hcbd_pkg::CH_LF, 1'b0);
    put_word("0", 1'b0);
    put_word(hcbd_pkg::CH_CR, 1'b0);
    put_word(hcbd_pkg::CH_LF, 1'b0);
    put_word("Z", 1'b0);
    // A digitless size line ends the message.
    put_word(hcbd_pkg::CH_CR, 1'b1);
    put_word(hcbd_pkg::CH_LF, 1'b0);
    // An extension longer than the slack sets the sticky error.
    put_word("F", 1'b1);
    repeat (12) put_word("x", 1'b0);
    drain_all();

    foreach (slack_plan[p]) begin
      write_slack(slack_plan[p]);
      fill_phase();
      if (p == 2) begin
        repeat (20) @(posedge clk_i);
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      drain_all();
    end

    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0)
      note_mismatch("results never produced", 32'd0, 32'(expected_results.size()));
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/hcbd_pkg.sv
src/hcbd_parser.sv
src/http_chunked_body_decoder_unit.sv
src/hcbd_checker.sv
tb/sv/tb_http_chunked_body_decoder_unit.sv
